>>> rtl/core/stp_pkg.sv
// Package for the stepper axis ramp and step generator.
// Widths, reset values, command and status codes, and the result record.
// No dependencies.
`default_nettype none
package stp_pkg;

    localparam int VELOCITY_BITS = 24;
    localparam int VEL_W         = VELOCITY_BITS;
    localparam int MAG_W         = VEL_W - 1;
    localparam int POS_W         = 64;
    localparam int PHASE_W       = 32;
    localparam int LEASE_W       = 16;
    localparam int RATE_W        = 24;
    localparam int CMD_W         = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 24;
    localparam int DIFF_W        = VEL_W + 2;

    localparam logic signed [VEL_W-1:0] VEL_LIMIT =
        VEL_W'((64'd1 << (VEL_W - 1)) - 64'd1);
    localparam logic signed [VEL_W-1:0] VEL_MIN =
        VEL_W'(64'd1 << (VEL_W - 1));

    localparam logic [MAG_W-1:0]   MAX_VEL_RST    = MAG_W'(0);
    localparam logic [MAG_W-1:0]   RAMP_RST       = MAG_W'(100);
    localparam logic [LEASE_W-1:0] LEASE_RST      = LEASE_W'(50);
    localparam logic [RATE_W-1:0]  SCHED_RATE_RST = RATE_W'(100000);

    typedef enum logic [CMD_W-1:0] {
        CMD_ENABLE      = 4'd0,
        CMD_DISABLE     = 4'd1,
        CMD_SET_VEL     = 4'd2,
        CMD_INT_VEL     = 4'd3,
        CMD_STOP        = 4'd4,
        CMD_FORCE_STOP  = 4'd5,
        CMD_SET_POS     = 4'd6,
        CMD_CTRL_TICK   = 4'd7,
        CMD_SCHED_TICK  = 4'd8,
        CMD_COMMIT_STEP = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        VS_OK        = 2'd0,
        VS_RANGE     = 2'd1,
        VS_DISABLED  = 2'd2,
        VS_DISABLING = 2'd3
    } t_vel_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_VEL    = 2'd0,
        CFG_RAMP       = 2'd1,
        CFG_LEASE      = 2'd2,
        CFG_SCHED_RATE = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_vel_status             velocity_status;
        logic                    disable_complete;
        logic                    direction_changed;
        logic                    direction_is_positive;
        logic                    disable_driver;
        logic                    step_due;
        logic signed [POS_W-1:0] position_out;
        logic signed [VEL_W-1:0] velocity_now;
        logic                    is_enabled;
        logic                    is_moving;
        logic                    timed_out;
    } t_res;

endpackage
`default_nettype wire

>>> rtl/core/stp_ifs.sv
// Channel interfaces: command beats in, result beats out, register writes.
// Depends on stp_pkg.
`default_nettype none
interface stp_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [stp_pkg::CMD_W-1:0]             command;
    logic signed [stp_pkg::VEL_W-1:0]      velocity;
    logic signed [stp_pkg::POS_W-1:0]      new_position;
    modport source(output valid, command, velocity, new_position, input ready);
    modport sink(input valid, command, velocity, new_position, output ready);
endinterface

interface stp_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            velocity_status;
    logic                                  disable_complete;
    logic                                  direction_changed;
    logic                                  direction_is_positive;
    logic                                  disable_driver;
    logic                                  step_due;
    logic signed [stp_pkg::POS_W-1:0]      position_out;
    logic signed [stp_pkg::VEL_W-1:0]      velocity_now;
    logic                                  is_enabled;
    logic                                  is_moving;
    logic                                  timed_out;
    modport source(output valid, velocity_status, disable_complete, direction_changed,
                   direction_is_positive, disable_driver, step_due, position_out,
                   velocity_now, is_enabled, is_moving, timed_out, input ready);
    modport sink(input valid, velocity_status, disable_complete, direction_changed,
                 direction_is_positive, disable_driver, step_due, position_out,
                 velocity_now, is_enabled, is_moving, timed_out, output ready);
endinterface

interface stp_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [stp_pkg::CFG_IDX_W-1:0]         reg_index;
    logic [stp_pkg::CFG_DATA_W-1:0]        wdata;
    modport source(output valid, reg_index, wdata, input ready);
    modport sink(input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

>>> rtl/core/stepper_axis_ramp_step_generator.sv
// Stepper axis velocity ramp and step generator, one command per beat.
// Depends on stp_pkg and the interfaces in stp_ifs.sv.
//
//   channel  dir  payload                                    accept
//   i_cmd    in   command, velocity, new_position            valid & ready
//   o_res    out  status, event flags, position, velocity    valid & ready
//   i_cfg    in   reg_index, wdata                           valid & ready (always ready)
//
// A beat is held in the input register and is resolved into the result register
// when that one is free or being taken; one beat per cycle while the result is not stalled.
// State updates as the beat moves into the result register, so the next beat
// sees them. Reset (synchronous) loads the register defaults and clears state.
// A stalled result holds the input register; the input side stalls only then.
`default_nettype none
module stepper_axis_ramp_step_generator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    stp_cmd_if.sink     i_cmd,
    stp_res_if.source   o_res,
    stp_cfg_if.sink     i_cfg
);

    localparam int VEL_W  = stp_pkg::VEL_W;
    localparam int MAG_W  = stp_pkg::MAG_W;
    localparam int POS_W  = stp_pkg::POS_W;
    localparam int PH_W   = stp_pkg::PHASE_W;
    localparam int LS_W   = stp_pkg::LEASE_W;
    localparam int RATE_W = stp_pkg::RATE_W;
    localparam int DIFF_W = stp_pkg::DIFF_W;

    // configuration
    logic [MAG_W-1:0]  r_max_vel;
    logic [MAG_W-1:0]  r_ramp;
    logic [LS_W-1:0]   r_lease_ticks;
    logic [RATE_W-1:0] r_sched_rate;

    // axis state
    logic signed [POS_W-1:0] r_position,  n_position;
    logic signed [VEL_W-1:0] r_target,    n_target;
    logic signed [VEL_W-1:0] r_cur,       n_cur;
    logic [PH_W-1:0]         r_phase,     n_phase;
    logic [LS_W-1:0]         r_lease,     n_lease;
    logic                    r_enabled,   n_enabled;
    logic                    r_moving,    n_moving;
    logic                    r_disabling, n_disabling;
    logic                    r_timeout,   n_timeout;
    logic                    r_dir,       n_dir;

    // input register
    logic                    r_in_vld;
    stp_pkg::t_cmd           r_in_cmd;
    logic signed [VEL_W-1:0] r_in_vel;
    logic signed [POS_W-1:0] r_in_pos;

    // result register
    logic                    r_out_vld;
    stp_pkg::t_res           r_out;
    stp_pkg::t_res           n_res;

    logic fire;

    assign fire        = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_cmd.ready = !r_in_vld || fire;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel     <= stp_pkg::MAX_VEL_RST;
            r_ramp        <= stp_pkg::RAMP_RST;
            r_lease_ticks <= stp_pkg::LEASE_RST;
            r_sched_rate  <= stp_pkg::SCHED_RATE_RST;
        end else if (i_cfg.valid) begin
            case (stp_pkg::t_cfg_reg'(i_cfg.reg_index))
                stp_pkg::CFG_MAX_VEL:    r_max_vel     <= i_cfg.wdata[MAG_W-1:0];
                stp_pkg::CFG_RAMP:       r_ramp        <= i_cfg.wdata[MAG_W-1:0];
                stp_pkg::CFG_LEASE:      r_lease_ticks <= i_cfg.wdata[LS_W-1:0];
                stp_pkg::CFG_SCHED_RATE: r_sched_rate  <= i_cfg.wdata[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_cmd <= stp_pkg::t_cmd'(i_cmd.command);
            r_in_vel <= i_cmd.velocity;
            r_in_pos <= i_cmd.new_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_target    <= '0;
            r_cur       <= '0;
            r_phase     <= '0;
            r_lease     <= '0;
            r_enabled   <= 1'b0;
            r_moving    <= 1'b0;
            r_disabling <= 1'b0;
            r_timeout   <= 1'b0;
            r_dir       <= 1'b1;
            r_out_vld   <= 1'b0;
        end else begin
            if (fire) begin
                r_position  <= n_position;
                r_target    <= n_target;
                r_cur       <= n_cur;
                r_phase     <= n_phase;
                r_lease     <= n_lease;
                r_enabled   <= n_enabled;
                r_moving    <= n_moving;
                r_disabling <= n_disabling;
                r_timeout   <= n_timeout;
                r_dir       <= n_dir;
                r_out_vld   <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_res;
        end
    end

    always_comb begin
        logic [VEL_W-1:0]         vel_abs;
        logic signed [VEL_W-1:0]  vel_clamped;
        logic signed [VEL_W-1:0]  goal;
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] step_d;
        logic [VEL_W-1:0]         cur_abs;
        logic [PH_W-1:0]          phase_sum;
        stp_pkg::t_vel_status     status;
        logic                     dis_done;
        logic                     dir_chg;
        logic                     drv_off;
        logic                     due;

        n_position  = r_position;
        n_target    = r_target;
        n_cur       = r_cur;
        n_phase     = r_phase;
        n_lease     = r_lease;
        n_enabled   = r_enabled;
        n_moving    = r_moving;
        n_disabling = r_disabling;
        n_timeout   = r_timeout;
        n_dir       = r_dir;
        status      = stp_pkg::VS_OK;
        dis_done    = 1'b0;
        dir_chg     = 1'b0;
        drv_off     = 1'b0;
        due         = 1'b0;

        vel_abs     = r_in_vel[VEL_W-1] ? VEL_W'(-r_in_vel) : VEL_W'(r_in_vel);
        vel_clamped = (r_in_vel == stp_pkg::VEL_MIN) ? -stp_pkg::VEL_LIMIT : r_in_vel;
        cur_abs     = r_cur[VEL_W-1] ? VEL_W'(-r_cur) : VEL_W'(r_cur);
        phase_sum   = r_phase + PH_W'(cur_abs);
        step_d      = DIFF_W'(r_ramp);
        goal        = r_target;
        diff        = '0;

        case (r_in_cmd)
            stp_pkg::CMD_ENABLE: begin
                if (!r_enabled) begin
                    n_target    = '0;
                    n_cur       = '0;
                    n_phase     = '0;
                    n_lease     = '0;
                    n_moving    = 1'b0;
                    n_disabling = 1'b0;
                    n_dir       = 1'b1;
                    n_enabled   = 1'b1;
                end
            end
            stp_pkg::CMD_DISABLE: begin
                n_target = '0;
                n_lease  = '0;
                if (!r_enabled || r_cur == '0) begin
                    n_cur       = '0;
                    n_phase     = '0;
                    n_moving    = 1'b0;
                    n_disabling = 1'b0;
                    n_enabled   = 1'b0;
                    dis_done    = 1'b1;
                end else begin
                    n_disabling = 1'b1;
                end
            end
            stp_pkg::CMD_SET_VEL: begin
                if (vel_abs > VEL_W'(r_max_vel)) begin
                    status = stp_pkg::VS_RANGE;
                end else if (!r_enabled) begin
                    status = stp_pkg::VS_DISABLED;
                end else if (r_disabling) begin
                    status = stp_pkg::VS_DISABLING;
                end else begin
                    n_target = vel_clamped;
                    if (vel_clamped == '0) begin
                        n_lease = '0;
                    end else begin
                        n_lease   = r_lease_ticks;
                        n_timeout = 1'b0;
                    end
                end
            end
            stp_pkg::CMD_INT_VEL: begin
                n_target  = vel_clamped;
                n_lease   = '0;
                n_timeout = 1'b0;
            end
            stp_pkg::CMD_STOP: begin
                n_target = '0;
                n_lease  = '0;
            end
            stp_pkg::CMD_FORCE_STOP: begin
                n_target = '0;
                n_cur    = '0;
                n_phase  = '0;
                n_lease  = '0;
                n_moving = 1'b0;
            end
            stp_pkg::CMD_SET_POS: begin
                n_position = r_in_pos;
            end
            stp_pkg::CMD_CTRL_TICK: begin
                if (r_lease != '0) begin
                    n_lease = r_lease - LS_W'(1);
                    if (r_lease == LS_W'(1)) begin
                        n_target  = '0;
                        n_timeout = 1'b1;
                        goal      = '0;
                    end
                end
                // reversal passes through zero
                if ((r_cur > 0 && goal < 0) || (r_cur < 0 && goal > 0)) begin
                    goal = '0;
                end
                diff = DIFF_W'(goal) - DIFF_W'(r_cur);
                if (diff > step_d) begin
                    n_cur = VEL_W'(DIFF_W'(r_cur) + step_d);
                end else if (diff < -step_d) begin
                    n_cur = VEL_W'(DIFF_W'(r_cur) - step_d);
                end else begin
                    n_cur = goal;
                end
                n_moving = (n_cur != '0);
                if (!n_moving) begin
                    n_phase = '0;
                    if (r_disabling) begin
                        n_disabling = 1'b0;
                        n_enabled   = 1'b0;
                        drv_off     = 1'b1;
                    end
                end else if (!n_cur[VEL_W-1]) begin
                    if (!r_dir) begin
                        n_dir   = 1'b1;
                        dir_chg = 1'b1;
                    end
                end else if (r_dir) begin
                    n_dir   = 1'b0;
                    dir_chg = 1'b1;
                end
            end
            stp_pkg::CMD_SCHED_TICK: begin
                if (r_cur == '0) begin
                    n_phase = '0;
                end else if (phase_sum >= PH_W'(r_sched_rate)) begin
                    n_phase = phase_sum - PH_W'(r_sched_rate);
                    due     = 1'b1;
                end else begin
                    n_phase = phase_sum;
                end
            end
            stp_pkg::CMD_COMMIT_STEP: begin
                n_position = r_dir ? r_position + POS_W'(1) : r_position - POS_W'(1);
            end
            default: begin
            end
        endcase

        n_res.velocity_status       = status;
        n_res.disable_complete      = dis_done;
        n_res.direction_changed     = dir_chg;
        n_res.direction_is_positive = n_dir;
        n_res.disable_driver        = drv_off;
        n_res.step_due              = due;
        n_res.position_out          = n_position;
        n_res.velocity_now          = n_cur;
        n_res.is_enabled            = n_enabled;
        n_res.is_moving             = n_moving;
        n_res.timed_out             = n_timeout;
    end

    assign o_res.valid                 = r_out_vld;
    assign o_res.velocity_status       = r_out.velocity_status;
    assign o_res.disable_complete      = r_out.disable_complete;
    assign o_res.direction_changed     = r_out.direction_changed;
    assign o_res.direction_is_positive = r_out.direction_is_positive;
    assign o_res.disable_driver        = r_out.disable_driver;
    assign o_res.step_due              = r_out.step_due;
    assign o_res.position_out          = r_out.position_out;
    assign o_res.velocity_now          = r_out.velocity_now;
    assign o_res.is_enabled            = r_out.is_enabled;
    assign o_res.is_moving             = r_out.is_moving;
    assign o_res.timed_out             = r_out.timed_out;

endmodule
`default_nettype wire

>>> rtl/core/stp_checker.sv
// Port-level checks on the result channel of the step generator, and the bind
// that attaches them. Depends on stp_pkg and the top level.
`default_nettype none
module stp_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_res_valid,
    input wire                               i_res_ready,
    input wire                               i_dir_changed,
    input wire                               i_dir_positive,
    input wire                               i_disable_driver,
    input wire signed [stp_pkg::VEL_W-1:0]   i_velocity_now,
    input wire                               i_is_enabled,
    input wire                               i_is_moving
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_is_moving == (i_velocity_now != '0)))
        else $error("moving flag disagrees with velocity");

    a_dir_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_dir_changed |->
            i_is_moving && (i_dir_positive == !i_velocity_now[stp_pkg::VEL_W-1]))
        else $error("direction change without matching motion");

    a_drv_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_disable_driver |->
            !i_is_enabled && !i_is_moving && (i_velocity_now == '0))
        else $error("driver disable while axis still active");

endmodule

bind stepper_axis_ramp_step_generator stp_checker u_stp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_dir_changed    (o_res.direction_changed),
    .i_dir_positive   (o_res.direction_is_positive),
    .i_disable_driver (o_res.disable_driver),
    .i_velocity_now   (o_res.velocity_now),
    .i_is_enabled     (o_res.is_enabled),
    .i_is_moving      (o_res.is_moving)
);
`default_nettype wire
